### hdl/cht_pkg.sv
// Shared constants and types for the chained hash table.
package cht_pkg;

    // Width of a key as it travels through the block.
    localparam int KEY_W = 31;

    // Operation codes carried on i_kind.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef logic [KEY_W-1:0] t_key;

endpackage

### hdl/cht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cht_bucket.sv
// Three-stage pipeline that reduces a key modulo the bucket count.
module cht_bucket #(
    parameter int BUCKETS = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  cht_pkg::t_key              i_key,
    output logic                       o_valid,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);
    import cht_pkg::*;

    localparam int BIW     = $clog2(BUCKETS);
    localparam int SHIFT_W = KEY_W + BIW;
    localparam int PROD_W  = KEY_W + 32;
    // floor(2^SHIFT_W / BUCKETS) fits in 32 bits for every bucket count.
    localparam logic [63:0] RecipFull = (64'd1 << SHIFT_W) / BUCKETS;
    localparam logic [31:0] Recip     = RecipFull[31:0];

    logic [2:0]        r_valid;
    logic [PROD_W-1:0] r_prod;
    t_key              r_key1;
    t_key              r_key2;
    t_key              r_qb;
    logic [BIW-1:0]    r_bucket;

    t_key quot;
    t_key rem;
    t_key rem_fix;

    // The reciprocal estimate is at most one low, so the remainder is below
    // twice the bucket count and one conditional subtract finishes it.
    assign quot    = KEY_W'(r_prod >> SHIFT_W);
    assign rem     = r_key2 - r_qb;
    assign rem_fix = (rem >= KEY_W'(BUCKETS)) ? rem - KEY_W'(BUCKETS) : rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= PROD_W'(i_key) * PROD_W'(Recip);
        r_key1   <= i_key;
        r_qb     <= KEY_W'(quot * KEY_W'(BUCKETS));
        r_key2   <= r_key1;
        r_bucket <= BIW'(rem_fix);
    end

    assign o_valid  = r_valid[2];
    assign o_bucket = r_bucket;

endmodule

### hdl/chained_hash_table.sv
// Top level of the chained hash table: control sequencer, head and node memories.
//
// Hash table with separate chaining over a fixed pool of nodes. A word is
// accepted when start is high and busy is low; it either inserts a key or
// searches for it. The bucket is the key modulo BUCKETS, computed by a
// three-stage reciprocal-multiply pipeline. An insert takes the next unused
// pool node, links it in at the head of its bucket chain and reports
// o_table_full when the pool is exhausted (the key is then dropped). A search
// walks the chain one node per cycle and reports o_found and the key on a hit;
// the newest duplicate is found first. Every word yields exactly one result,
// shown for one cycle with o_done high; the receiver cannot stall it. An
// insert and a search of an empty bucket end after the head read; a search
// of a used bucket then walks its chain through the single read port of the
// node memory. One word is handled at a time and busy stays high until its
// result is out. After reset the block clears every head entry, with busy
// high.
module chained_hash_table #(
    parameter int BUCKETS    = 19,
    parameter int POOL_NODES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_kind,
    input  cht_pkg::t_key i_key_value,
    output logic          o_done,
    output logic          o_found,
    output cht_pkg::t_key o_found_value,
    output logic          o_table_full
);
    import cht_pkg::*;

    localparam int BIW    = $clog2(BUCKETS);
    localparam int NIW    = $clog2(POOL_NODES);
    localparam int CW     = $clog2(POOL_NODES + 1);
    localparam int HEAD_W = NIW + 1;
    localparam int NODE_W = KEY_W + 1 + NIW;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_HEAD  = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;

    logic [2:0]     r_state, n_state;
    logic [BIW-1:0] r_clr_addr, n_clr_addr;
    logic [CW-1:0]  r_taken, n_taken;
    logic           r_kind;
    t_key           r_key;
    logic [BIW-1:0] r_bucket, n_bucket;
    logic           r_done, n_done;
    logic           r_found, n_found;
    t_key           r_found_value, n_found_value;
    logic           r_table_full, n_table_full;

    logic           accept;
    logic           bkt_valid;
    logic [BIW-1:0] bkt_index;

    // Head memory entry: used flag and the node at the head of the chain.
    logic              head_we;
    logic [BIW-1:0]    head_waddr;
    logic [HEAD_W-1:0] head_wdata;
    logic [HEAD_W-1:0] head_rdata;
    logic              head_used;
    logic [NIW-1:0]    head_node;

    // Node memory entry: key, has-successor flag and successor index.
    logic              node_we;
    logic [NIW-1:0]    node_raddr;
    logic [NODE_W-1:0] node_wdata;
    logic [NODE_W-1:0] node_rdata;
    t_key              node_key;
    logic              node_has_link;
    logic [NIW-1:0]    node_link;

    logic pool_full;

    assign accept    = start && !busy;
    assign pool_full = (r_taken == CW'(POOL_NODES));

    assign head_used = head_rdata[HEAD_W-1];
    assign head_node = head_rdata[NIW-1:0];

    assign node_key      = node_rdata[NODE_W-1 -: KEY_W];
    assign node_has_link = node_rdata[NIW];
    assign node_link     = node_rdata[NIW-1:0];

    cht_bucket #(
        .BUCKETS (BUCKETS)
    ) u_bucket (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_key    (i_key_value),
        .o_valid  (bkt_valid),
        .o_bucket (bkt_index)
    );

    cht_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (bkt_index),
        .o_rdata (head_rdata)
    );

    cht_ram #(
        .WIDTH (NODE_W),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (r_taken[NIW-1:0]),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // The new node inherits the old head as its successor; the bucket then
    // points at the new node. During the clearing pass every head entry is
    // written as unused.
    assign node_wdata = {r_key, head_used, head_node};
    assign node_raddr = (r_state == ST_WALK) ? node_link : head_node;

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_taken       = r_taken;
        n_bucket      = r_bucket;
        n_done        = 1'b0;
        n_found       = 1'b0;
        n_found_value = '0;
        n_table_full  = 1'b0;
        head_we       = 1'b0;
        head_waddr    = r_bucket;
        head_wdata    = {1'b1, r_taken[NIW-1:0]};
        node_we       = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr_addr;
                head_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == BIW'(BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                // The head read is issued at the bucket from the pipeline.
                if (bkt_valid) begin
                    n_bucket = bkt_index;
                    n_state  = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (r_kind == KIND_INSERT) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                    if (pool_full) begin
                        n_table_full = 1'b1;
                    end else begin
                        node_we = 1'b1;
                        head_we = 1'b1;
                        n_taken = r_taken + 1'b1;
                    end
                end else if (!head_used) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                // Chains are acyclic, so the walk always ends on a match or
                // on a node without a successor.
                if (node_key == r_key) begin
                    n_done        = 1'b1;
                    n_found       = 1'b1;
                    n_found_value = r_key;
                    n_state       = ST_IDLE;
                end else if (!node_has_link) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_taken    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_taken    <= n_taken;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_key  <= i_key_value;
        end
        r_bucket      <= n_bucket;
        r_found       <= n_found;
        r_found_value <= n_found_value;
        r_table_full  <= n_table_full;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_found_value = r_found_value;
    assign o_table_full  = r_table_full;

`ifndef SYNTH
    // A result is never followed by another in the next cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // The pool count never runs past the pool size.
    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= CW'(POOL_NODES))
        else $error("node count exceeds the pool");

    // A dropped insert and a search hit are never reported together.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_table_full) |-> !o_found)
        else $error("table full and found reported together");

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("block not busy after accepting a word");

    // The node count only moves on an insert that stores its key.
    a_taken_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_taken != $past(r_taken)) |-> $past(node_we))
        else $error("node count changed without a node write");
`endif

endmodule
